/* rtl/core/itaf_pkg.sv */
// itaf_pkg: shared constants, types and digit conversion function for the integer formatter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package itaf_pkg;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_FIELD_DEF  = 60;
    localparam int MAX_OUT        = 63;

    localparam int FL_LEFT   = 0;
    localparam int FL_PLUS   = 1;
    localparam int FL_SPACE  = 2;
    localparam int FL_PREFIX = 3;
    localparam int FL_ZERO   = 4;
    localparam int FL_UPPER  = 5;
    localparam int FL_SIGNED = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    // classified request handed from front to back
    typedef struct packed {
        logic        bad;
        logic [63:0] mag;
        logic [5:0]  radix;
        logic [6:0]  size;
        logic [6:0]  prec;
        logic [7:0]  sign_ch;
        logic        has_sign;
        logic [7:0]  pfx_ch;
        logic        has_pfx;
        logic        left;
        logic        zero;
        logic        upper;
    } t_req;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic up);
        logic [7:0] c;
        if (d < 6'd10) c = CH_ZERO + {2'b0, d};
        else if (up)   c = 8'h41 + {2'b0, d} - 8'd10;
        else           c = 8'h61 + {2'b0, d} - 8'd10;
        return c;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/itaf_if.sv */
// itaf_if: valid/ready channel carrying a payload type
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface itaf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/itaf_front.sv */
// itaf_front: accepts a request, works out sign, magnitude, prefix and widths
// depends on itaf_pkg
`timescale 1ns / 1ps
`default_nettype none
module itaf_front #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 60
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [31:0]     i_value,
    input  wire logic [5:0]      i_radix,
    input  wire logic [6:0]      i_field_width,
    input  wire logic [6:0]      i_min_digits,
    input  wire logic [6:0]      i_format_flags,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output itaf_pkg::t_req       o_req
);
    import itaf_pkg::*;
    localparam logic signed [7:0] MAXF = 8'(MAX_FIELD);
    logic r_valid;
    t_req r_req, n_req;
    logic signed [7:0] w_size, w_prec;
    logic [6:0] w_fl;
    logic [VALUE_BITS-1:0] w_v;
    logic w_neg, w_pfx_base;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_comb begin
        w_fl = i_format_flags;
        if (w_fl[FL_LEFT]) w_fl[FL_ZERO] = 1'b0;
        w_v = VALUE_BITS'(i_value);
        w_size = 8'(signed'(i_field_width));
        w_prec = 8'(signed'(i_min_digits));
        if (w_size > MAXF) w_size = MAXF;
        if (w_prec > MAXF) w_prec = MAXF;
        w_neg = w_fl[FL_SIGNED] && w_v[VALUE_BITS-1];
        w_pfx_base = (i_radix == 6'd16) || (i_radix == 6'd8) || (i_radix == 6'd2);
        n_req = '0;
        n_req.bad = (i_radix < 6'd2) || (i_radix > 6'd36);
        n_req.radix = i_radix;
        n_req.mag = 64'(w_neg ? (~w_v + 1'b1) : w_v);
        n_req.has_sign = w_fl[FL_SIGNED] && (w_neg || w_fl[FL_PLUS] || w_fl[FL_SPACE]);
        n_req.sign_ch = w_neg ? CH_MINUS : (w_fl[FL_PLUS] ? CH_PLUS : CH_SPACE);
        if (n_req.has_sign) w_size = w_size - 8'sd1;
        n_req.has_pfx = w_fl[FL_PREFIX] && w_pfx_base;
        if (n_req.has_pfx) w_size = w_size - 8'sd2;
        n_req.pfx_ch = digit_char((i_radix == 6'd16) ? 6'd33 :
                                  (i_radix == 6'd8) ? 6'd24 : 6'd11, w_fl[FL_UPPER]);
        // negative means none
        n_req.size = (w_size < 0) ? 7'd0 : w_size[6:0];
        n_req.prec = (w_prec < 0) ? 7'd0 : w_prec[6:0];
        n_req.left = w_fl[FL_LEFT];
        n_req.zero = w_fl[FL_ZERO];
        n_req.upper = w_fl[FL_UPPER];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) r_req <= n_req;
    end
endmodule
`default_nettype wire

/* rtl/core/itaf_back.sv */
// itaf_back: bit-serial digit extraction and character sequencer
// depends on itaf_pkg
`timescale 1ns / 1ps
`default_nettype none
module itaf_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire itaf_pkg::t_req i_req,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_char,
    output logic             o_last_char,
    output logic             o_bad_radix
);
    import itaf_pkg::*;
    localparam int BW = $clog2(VALUE_BITS + 1);
    localparam int IW = $clog2(VALUE_BITS);
    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_PLAN, S_EMIT
    } t_state;
    typedef enum logic [2:0] {
        P_LPAD, P_SIGN, P_PFX0, P_PFX1, P_ZPAD, P_DIG, P_RPAD, P_DONE
    } t_phase;

    t_state r_state;
    t_phase r_ph, w_ph_nx;
    t_req   r_req;
    logic [VALUE_BITS-1:0] r_quo;
    logic [5:0]  r_rem;
    logic [BW-1:0] r_bit;
    logic [5:0]  r_dig [VALUE_BITS];
    logic [BW-1:0] r_nd;
    logic [6:0]  r_pad, r_zeros, r_cnt;
    logic [6:0]  r_nout, r_total;
    logic        r_ov;
    logic [7:0]  r_ch;
    logic        r_last, r_bad;
    logic [6:0]  w_rem_sh;
    logic        w_ge;
    logic [6:0]  w_ph_len;
    logic [7:0]  w_ch;
    logic [6:0]  w_zeros, w_digs, w_pad, w_total;
    logic        w_final;

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_out_char = r_ch;
    assign o_last_char = r_last;
    assign o_bad_radix = r_bad;

    // restoring division, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge = w_rem_sh >= {1'b0, r_req.radix};

    // text length plan once the digit count is known
    assign w_zeros = (7'(r_nd) < r_req.prec) ? r_req.prec - 7'(r_nd) : 7'd0;
    assign w_digs  = 7'(r_nd) + w_zeros;
    assign w_pad   = (r_req.size > w_digs) ? r_req.size - w_digs : 7'd0;
    assign w_total = w_pad + w_digs + {6'd0, r_req.has_sign} + {5'd0, r_req.has_pfx, 1'b0};
    assign w_final = (r_nout == r_total - 7'd1) || (r_nout == 7'(MAX_OUT - 1));

    always_comb begin
        w_ph_len = 7'd0;
        case (r_ph)
            P_LPAD: w_ph_len = (!r_req.left && !r_req.zero) ? r_pad : 7'd0;
            P_SIGN: w_ph_len = {6'd0, r_req.has_sign};
            P_PFX0: w_ph_len = {6'd0, r_req.has_pfx};
            P_PFX1: w_ph_len = {6'd0, r_req.has_pfx};
            P_ZPAD: w_ph_len = r_req.zero ? (r_pad + r_zeros) : r_zeros;
            P_DIG:  w_ph_len = 7'(r_nd);
            P_RPAD: w_ph_len = r_req.left ? r_pad : 7'd0;
            default: w_ph_len = 7'd0;
        endcase
        case (r_ph)
            P_LPAD: w_ch = CH_SPACE;
            P_SIGN: w_ch = r_req.sign_ch;
            P_PFX0: w_ch = CH_ZERO;
            P_PFX1: w_ch = r_req.pfx_ch;
            P_ZPAD: w_ch = CH_ZERO;
            // digits are stored least significant first
            P_DIG:  w_ch = digit_char(r_dig[IW'(r_nd - 1'b1 - r_cnt[BW-1:0])], r_req.upper);
            P_RPAD: w_ch = CH_SPACE;
            default: w_ch = CH_SPACE;
        endcase
        w_ph_nx = t_phase'(r_ph + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_ov) begin
                        if (i_ready) r_ov <= 1'b0;
                    end else if (i_valid) begin
                        r_req <= i_req;
                        if (i_req.bad) begin
                            r_ch <= 8'd0; r_last <= 1'b1; r_bad <= 1'b1;
                            r_ov <= 1'b1;
                        end else begin
                            r_quo <= i_req.mag[VALUE_BITS-1:0];
                            r_rem <= '0;
                            r_bit <= '0;
                            r_nd <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quo <= {r_quo[VALUE_BITS-2:0], w_ge};
                    r_rem <= w_ge ? 6'(w_rem_sh - {1'b0, r_req.radix}) : w_rem_sh[5:0];
                    if (r_bit == BW'(VALUE_BITS - 1)) begin
                        r_dig[r_nd[IW-1:0]] <= w_ge ? 6'(w_rem_sh - {1'b0, r_req.radix})
                                                    : w_rem_sh[5:0];
                        r_nd <= r_nd + 1'b1;
                        r_bit <= '0;
                        r_rem <= '0;
                        if ({r_quo[VALUE_BITS-2:0], w_ge} == '0) r_state <= S_PLAN;
                    end else begin
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_PLAN: begin
                    // zero value still gives one digit from the division pass
                    r_zeros <= w_zeros;
                    r_pad <= w_pad;
                    r_total <= w_total;
                    r_ph <= P_LPAD;
                    r_cnt <= 7'd0;
                    r_nout <= 7'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ov || i_ready) begin
                        if (r_cnt < w_ph_len) begin
                            r_ch <= w_ch; r_last <= w_final; r_bad <= 1'b0;
                            r_ov <= 1'b1;
                            r_nout <= r_nout + 7'd1;
                            r_cnt <= r_cnt + 7'd1;
                            if (w_final) r_state <= S_IDLE;
                        end else begin
                            r_ov <= 1'b0;
                            r_ph <= w_ph_nx;
                            r_cnt <= 7'd0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/core/integer_to_ascii_formatter_core.sv */
// integer_to_ascii_formatter_core: top level joining front classifier and back sequencer
// depends on itaf_pkg, itaf_if, itaf_front, itaf_back
// flow: front register, load into the back part, bit-serial division for each digit, plan,
// then characters emitted phase by phase
// throughput: one request at a time in the back part; the front register holds the next one
// reset: synchronous active low, clears valid flags and sequencer state only
`timescale 1ns / 1ps
`default_nettype none
module integer_to_ascii_formatter_core #(
    parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF,
    parameter int MAX_FIELD  = itaf_pkg::MAX_FIELD_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_value,
    input  wire logic [5:0]  i_radix,
    input  wire logic [6:0]  i_field_width,
    input  wire logic [6:0]  i_min_digits,
    input  wire logic [6:0]  i_format_flags,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_char,
    output logic             o_last_char,
    output logic             o_bad_radix
);
    import itaf_pkg::*;
    // front-to-back request channel
    itaf_if #(.T(t_req)) u_q ();

    itaf_front #(.VALUE_BITS(VALUE_BITS), .MAX_FIELD(MAX_FIELD)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_value, .i_radix, .i_field_width, .i_min_digits, .i_format_flags,
        .o_valid(u_q.valid), .i_ready(u_q.ready), .o_req(u_q.data)
    );

    itaf_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(u_q.valid), .o_ready(u_q.ready), .i_req(u_q.data),
        .o_valid, .i_ready, .o_out_char, .o_last_char, .o_bad_radix
    );
endmodule
`default_nettype wire
